// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, muted while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ipv4dq_pkg.sv
// ---------------------------------------------------------------------------
// ipv4dq_pkg
// Types, codes and helper functions shared by the address validator files.
// ---------------------------------------------------------------------------
package ipv4dq_pkg;

	// character class codes
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_OTHER = 2'd0;
	localparam cls_t CLS_DIGIT = 2'd1;
	localparam cls_t CLS_DOT   = 2'd2;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	// register byte address
	localparam logic REG_CHECK_MODE = 1'b0;

	// classified character, front to back
	typedef struct packed {
		logic       last;
		cls_t       cls;
		logic [3:0] digit;
	} item_t;

	// output payload widths
	localparam int unsigned OUT_BITS  = 1 + 32 + 6;
	localparam int unsigned OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

	// ones in one byte of a contiguous mask; other bytes give zero; the sum is output only for a valid mask
	function automatic logic [3:0] mask_byte_ones(input logic [7:0] b);
		logic [3:0] n;
		unique case (b)
			8'd128:  n = 4'd1;
			8'd192:  n = 4'd2;
			8'd224:  n = 4'd3;
			8'd240:  n = 4'd4;
			8'd248:  n = 4'd5;
			8'd252:  n = 4'd6;
			8'd254:  n = 4'd7;
			8'd255:  n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// File: hw/rtl/ipv4_dotted_quad_validator.sv
// ---------------------------------------------------------------------------
// ipv4_dotted_quad_validator
// Streaming dotted-decimal IPv4 address and subnet mask checker.
// ---------------------------------------------------------------------------
// Feed the string one ASCII byte per request on the slave stream, tlast on its
// final byte. Each string yields one result request on the master stream:
// is_valid, the packed 32-bit value (first octet in the top byte, zero when
// invalid) and, in mask mode, the prefix length. A new character is taken
// every cycle while s_tready is high; the back end updates the octet
// combinationally (value times ten plus digit, compare against 255). After its
// tlast byte is accepted, a result passes the queue, the verdict stage and the
// output register in that order before m_tvalid rises. A last byte waits at
// the queue head while the verdict stage is still held by a stalled result;
// the queue then fills and s_tready drops.
// check_mode is taken with each string's last byte and should only be
// written while no string is in flight.
// ---------------------------------------------------------------------------
module ipv4_dotted_quad_validator #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// character stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_char
	// verdict stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [ipv4dq_pkg::OUT_TDATA-1:0] m_tdata, // [0] is_valid,
	                                                  // [32:1] address_value,
	                                                  // [38:33] prefix_length
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned ITEM_W = $bits(ipv4dq_pkg::item_t);

	logic              check_mode_q;
	ipv4dq_pkg::item_t front_item;
	ipv4dq_pkg::item_t back_item;
	logic [ITEM_W-1:0] pop_bits;
	logic              q_valid, q_ready;

	// register file: one bit, byte address 0
	assign pready = 1'b1;
	assign prdata = (paddr == ipv4dq_pkg::REG_CHECK_MODE) ? {31'b0, check_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
			&& paddr == ipv4dq_pkg::REG_CHECK_MODE) begin
			check_mode_q <= pwdata[0];
		end
	end

	// front: classify the incoming byte
	ipv4dq_front u_front (
		.char_code (s_tdata),
		.last_char (s_tlast),
		.item      (front_item)
	);

	// queue decouples classification from the parse state
	ipv4dq_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_tvalid),
		.push_ready (s_tready),
		.push_data  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (pop_bits)
	);

	assign back_item = ipv4dq_pkg::item_t'(pop_bits);

	// back: octet tracking, verdict, mask check and output register
	ipv4dq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.check_mode (check_mode_q),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (back_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// File: hw/rtl/ipv4dq_front.sv
// ---------------------------------------------------------------------------
// ipv4dq_front
// Classifies one incoming byte as digit, dot or other character.
// ---------------------------------------------------------------------------
module ipv4dq_front (
	input  logic               [7:0] char_code,
	input  logic                     last_char,
	output ipv4dq_pkg::item_t        item
);

	logic [7:0] ofs;

	assign ofs = char_code - ipv4dq_pkg::CHAR_ZERO;

	always_comb begin
		item.last  = last_char;
		item.digit = ofs[3:0];
		if (char_code >= ipv4dq_pkg::CHAR_ZERO && char_code <= ipv4dq_pkg::CHAR_NINE) begin
			item.cls = ipv4dq_pkg::CLS_DIGIT;
		end else if (char_code == ipv4dq_pkg::CHAR_DOT) begin
			item.cls = ipv4dq_pkg::CLS_DOT;
		end else begin
			item.cls = ipv4dq_pkg::CLS_OTHER;
		end
	end

endmodule

// File: hw/rtl/ipv4dq_fifo.sv
// ---------------------------------------------------------------------------
// ipv4dq_fifo
// Short register queue between front and back; push and pop can happen in the same cycle unless empty or full.
// ---------------------------------------------------------------------------
module ipv4dq_fifo #(
	parameter int unsigned WIDTH = 7,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push, pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/ipv4dq_back.sv
// ---------------------------------------------------------------------------
// ipv4dq_back
// Per-character parse state, end-of-string verdict and mask check.
// ---------------------------------------------------------------------------
module ipv4dq_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 check_mode,
	input  logic                                 q_valid,
	output logic                                 q_ready,
	input  ipv4dq_pkg::item_t                    q_item,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ipv4dq_pkg::OUT_TDATA-1:0]     m_tdata
);

	// parse state
	logic [7:0]  ov_q;
	logic [1:0]  dc_q;
	logic        lz_q;
	logic [1:0]  dots_q;
	logic        fail_q;
	logic [23:0] packed_q;

	logic [7:0]  ov_n;
	logic [1:0]  dc_n;
	logic        lz_n;
	logic [1:0]  dots_n;
	logic        fail_n;
	logic [23:0] packed_n;
	logic [11:0] times10;

	// verdict stage
	logic        valid_s1;
	logic        ok_s1;
	logic        mode_s1;
	logic [31:0] value_s1;

	// output register
	logic        out_valid_q;
	logic [ipv4dq_pkg::OUT_TDATA-1:0] out_data_q;

	logic        pop, s1_adv, s1_free;
	logic [31:0] inv;
	logic        mask_ok, final_ok;
	logic [5:0]  prefix;

	assign times10 = ({4'b0, ov_q} << 3) + ({4'b0, ov_q} << 1) + {8'b0, q_item.digit};

	always_comb begin
		ov_n     = ov_q;
		dc_n     = dc_q;
		lz_n     = lz_q;
		dots_n   = dots_q;
		fail_n   = fail_q;
		packed_n = packed_q;
		unique case (q_item.cls)
			ipv4dq_pkg::CLS_DIGIT: begin
				if (dc_q == 2'd3 || lz_q) begin
					fail_n = 1'b1;
				end else if (times10 > 12'd255) begin
					fail_n = 1'b1;
				end else begin
					if (dc_q == 2'd0 && q_item.digit == 4'd0) begin
						lz_n = 1'b1;
					end
					ov_n = times10[7:0];
					dc_n = dc_q + 2'd1;
				end
			end
			ipv4dq_pkg::CLS_DOT: begin
				if (dc_q == 2'd0 || dots_q == 2'd3) begin
					fail_n = 1'b1;
				end else begin
					packed_n = {packed_q[15:0], ov_q};
					dots_n   = dots_q + 2'd1;
					ov_n     = '0;
					dc_n     = '0;
					lz_n     = 1'b0;
				end
			end
			default: begin
				fail_n = 1'b1;
			end
		endcase
	end

	assign s1_adv  = valid_s1 && (!out_valid_q || m_tready);
	assign s1_free = !valid_s1 || s1_adv;
	assign q_ready = !q_item.last || s1_free;
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q     <= '0;
			dc_q     <= '0;
			lz_q     <= 1'b0;
			dots_q   <= '0;
			fail_q   <= 1'b0;
			packed_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop && q_item.last) begin
				ov_q     <= '0;
				dc_q     <= '0;
				lz_q     <= 1'b0;
				dots_q   <= '0;
				fail_q   <= 1'b0;
				packed_q <= '0;
			end else if (pop) begin
				ov_q     <= ov_n;
				dc_q     <= dc_n;
				lz_q     <= lz_n;
				dots_q   <= dots_n;
				fail_q   <= fail_n;
				packed_q <= packed_n;
			end
			if (pop && q_item.last) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.last) begin
			ok_s1    <= !fail_n && dots_n == 2'd3 && dc_n != 2'd0;
			mode_s1  <= check_mode;
			value_s1 <= {packed_n, ov_n};
		end
	end

	// mask: ones from the top, nonzero; prefix is the ones count
	assign inv     = ~value_s1;
	assign mask_ok = (value_s1 != 32'd0) && ((inv & (inv + 32'd1)) == 32'd0);
	assign prefix  = {2'b0, ipv4dq_pkg::mask_byte_ones(value_s1[31:24])}
		+ {2'b0, ipv4dq_pkg::mask_byte_ones(value_s1[23:16])}
		+ {2'b0, ipv4dq_pkg::mask_byte_ones(value_s1[15:8])}
		+ {2'b0, ipv4dq_pkg::mask_byte_ones(value_s1[7:0])};
	assign final_ok = ok_s1 && (!mode_s1 || mask_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= ipv4dq_pkg::OUT_TDATA'({
				(final_ok && mode_s1) ? prefix : 6'd0,
				final_ok ? value_s1 : 32'd0,
				final_ok
			});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// File: hw/rtl/ipv4dq_chk.sv
// ---------------------------------------------------------------------------
// ipv4dq_chk
// Port-level checks on the verdict stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4dq_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [ipv4dq_pkg::OUT_TDATA-1:0]     m_tdata
);

	`ASSERT_NEXT(a_stall_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "verdict dropped under stall")
	`ASSERT_NEXT(a_stall_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "verdict changed under stall")
	`ASSERT_IMPL(a_invalid_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0 && m_tdata[38:33] == 6'd0, "invalid verdict with nonzero value")
	`ASSERT_IMPL(a_prefix_mask, clk, arst_n, m_tvalid && m_tdata[38:33] != 6'd0, m_tdata[0] && m_tdata[32] && m_tdata[38:33] <= 6'd32, "prefix without valid mask")

endmodule

bind ipv4_dotted_quad_validator ipv4dq_chk u_chk (.*);
